// File: sv/utf32_to_utf8_four_lane_encoder_assert.svh
// Assertion macros for the UTF-32 to UTF-8 encoder.
// Both expect clk and arst_n in the scope of the use.
`ifndef UTF32_TO_UTF8_FOUR_LANE_ENCODER_ASSERT_SVH
`define UTF32_TO_UTF8_FOUR_LANE_ENCODER_ASSERT_SVH

// Same-cycle implication
`define U8E_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u32u8enc: same-cycle check failed");

// Next-cycle implication
`define U8E_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u32u8enc: next-cycle check failed");

`endif

// File: sv/u32u8enc_pkg.sv
package u32u8enc_pkg;

	// Lane count of the core and number of words in one request
	localparam int LANES        = 4;
	localparam int IN_WORDS     = 4;
	localparam int ACTIVE_LANES = (LANES < IN_WORDS) ? LANES : IN_WORDS;
	localparam logic [2:0] ACTIVE_LANES_W = 3'(ACTIVE_LANES);

	// Configuration register indexes
	localparam logic CFG_VALIDATE  = 1'b0;
	localparam logic CFG_STOP_NULL = 1'b1;

	// Code point boundaries
	localparam logic [31:0] CP_1B_LIMIT   = 32'h0000_0080;
	localparam logic [31:0] CP_2B_LIMIT   = 32'h0000_0800;
	localparam logic [31:0] CP_3B_LIMIT   = 32'h0001_0000;
	localparam logic [31:0] CP_MAX_PLUS1  = 32'h0011_0000;
	localparam logic [31:0] SURR_MASK     = 32'h001F_F800;
	localparam logic [31:0] SURR_BASE     = 32'h0000_D800;
	localparam logic [31:0] NONCHAR_LO    = 32'h0000_FDD0;
	localparam logic [31:0] NONCHAR_HI    = 32'h0000_FDEF;
	localparam logic [31:0] NONCHAR_LOW16 = 32'h0000_FFFE;

	// UTF-8 lead and continuation byte marks
	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_TERM    = 2'd2
	} status_t;

	typedef struct packed {
		logic validate_enable;
		logic stop_at_null;
	} cfg_t;

	// What one lane found for its word
	typedef struct packed {
		logic        act;    // word is present
		logic        term;   // zero word in null-terminated mode
		logic        bad;    // rejected by validation
		logic [2:0]  len;    // UTF-8 length, 1..4
		logic [31:0] bytes;  // byte 0 in bits 7:0, unused bytes zero
	} lane_t;

endpackage

// File: sv/u32u8enc_lane.sv
module u32u8enc_lane (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 act,
	input  logic [31:0]          cp,
	input  u32u8enc_pkg::cfg_t   cfg,
	output u32u8enc_pkg::lane_t  lane_s1
);
	import u32u8enc_pkg::*;

	logic  invalid;
	lane_t lane_d;

	// Validation: out of range, surrogate, noncharacter
	always_comb begin
		invalid = 1'b0;
		if (cp >= CP_MAX_PLUS1)
			invalid = 1'b1;
		if ((cp & SURR_MASK) == SURR_BASE)
			invalid = 1'b1;
		if (cp inside {[NONCHAR_LO:NONCHAR_HI]})
			invalid = 1'b1;
		if ((cp & NONCHAR_LOW16) == NONCHAR_LOW16)
			invalid = 1'b1;
	end

	// Encode one word
	always_comb begin
		lane_d      = '0;
		lane_d.act  = act;
		lane_d.term = cfg.stop_at_null && (cp == '0);
		lane_d.bad  = cfg.validate_enable && invalid;
		if (cp < CP_1B_LIMIT) begin
			lane_d.len   = 3'd1;
			lane_d.bytes = {24'h0, cp[7:0]};
		end else if (cp < CP_2B_LIMIT) begin
			lane_d.len   = 3'd2;
			lane_d.bytes = {16'h0,
				CONT_B | {2'b00, cp[5:0]},
				LEAD_2B | {3'b000, cp[10:6]}};
		end else if (cp < CP_3B_LIMIT) begin
			lane_d.len   = 3'd3;
			lane_d.bytes = {8'h0,
				CONT_B | {2'b00, cp[5:0]},
				CONT_B | {2'b00, cp[11:6]},
				LEAD_3B | {4'b0000, cp[15:12]}};
		end else begin
			// bits above 20 are dropped
			lane_d.len   = 3'd4;
			lane_d.bytes = {
				CONT_B | {2'b00, cp[5:0]},
				CONT_B | {2'b00, cp[11:6]},
				CONT_B | {2'b00, cp[17:12]},
				LEAD_4B | {5'b00000, cp[20:18]}};
		end
	end

	// Stage 1 register
	always_ff @(posedge clk) begin
		if (load)
			lane_s1 <= lane_d;
	end

endmodule

// File: sv/u32u8enc_merge.sv
module u32u8enc_merge (
	input  logic                 clk,
	input  logic                 load,
	input  u32u8enc_pkg::lane_t  lanes_s1 [u32u8enc_pkg::ACTIVE_LANES],
	output logic [63:0]          bytes_low,
	output logic [63:0]          bytes_high,
	output logic [4:0]           byte_count,
	output logic [2:0]           lanes_done,
	output logic [1:0]           status
);
	import u32u8enc_pkg::*;

	logic [127:0] packed_d;
	logic [4:0]   pos_d;
	logic [2:0]   done_d;
	status_t      status_d;
	logic         hit;

	logic [127:0] packed_s2;
	logic [4:0]   pos_s2;
	logic [2:0]   done_s2;
	status_t      status_s2;

	// Walk the lanes in order; first absent, terminator or invalid lane ends it
	always_comb begin
		packed_d = '0;
		pos_d    = '0;
		done_d   = '0;
		status_d = ST_OK;
		hit      = 1'b0;
		for (int k = 0; k < ACTIVE_LANES; k++) begin
			if (!hit) begin
				if (!lanes_s1[k].act) begin
					hit = 1'b1;
				end else if (lanes_s1[k].term) begin
					hit      = 1'b1;
					status_d = ST_TERM;
				end else if (lanes_s1[k].bad) begin
					hit      = 1'b1;
					status_d = ST_INVALID;
				end else begin
					packed_d = packed_d | ({96'h0, lanes_s1[k].bytes} << {pos_d, 3'b000});
					pos_d    = pos_d + {2'b00, lanes_s1[k].len};
					done_d   = done_d + 3'd1;
				end
			end
		end
	end

	// Stage 2 / output register
	always_ff @(posedge clk) begin
		if (load) begin
			packed_s2 <= packed_d;
			pos_s2    <= pos_d;
			done_s2   <= done_d;
			status_s2 <= status_d;
		end
	end

	assign bytes_low  = packed_s2[63:0];
	assign bytes_high = packed_s2[127:64];
	assign byte_count = pos_s2;
	assign lanes_done = done_s2;
	assign status     = status_s2;

endmodule

// File: sv/utf32_to_utf8_four_lane_encoder.sv
// UTF-32 to UTF-8 encoder, four lanes. Each request carries up to four code
// points (lanes_valid of them, saturated to four); the result gives their
// UTF-8 bytes packed densely in lane order (byte 0 in bytes_low[7:0], unused
// bytes zero), the byte count, the number of words encoded and a status that
// says whether encoding stopped at an invalid word or a zero terminator at
// lane lanes_done. One lane encoder per word feeds a
// stage 1 register, then a merge stage packs the bytes into the output
// register. One request is accepted every cycle; a stalled output only holds
// the input off once both stages are full. Configuration (validate_enable at
// index 0, reset 1; stop_at_null at index 1, reset 0) may only be written
// while no request is in flight.
`include "utf32_to_utf8_four_lane_encoder_assert.svh"

module utf32_to_utf8_four_lane_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// request
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] code_point_0,
	input  logic [31:0] code_point_1,
	input  logic [31:0] code_point_2,
	input  logic [31:0] code_point_3,
	input  logic [2:0]  lanes_valid,
	// result
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] bytes_low,
	output logic [63:0] bytes_high,
	output logic [4:0]  byte_count,
	output logic [2:0]  lanes_done,
	output logic [1:0]  status
);
	import u32u8enc_pkg::*;

	cfg_t        cfg_q;
	logic [31:0] cp_in [IN_WORDS];
	logic [2:0]  n_lanes;
	lane_t       lanes_s1 [ACTIVE_LANES];
	logic        valid_s1;
	logic        valid_s2;
	logic        ready_s1;
	logic        ready_s2;
	logic        accept_in;
	logic        load_s2;
	logic [4:0]  done_ext;
	logic [4:0]  done_x4;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.validate_enable <= 1'b1;
			cfg_q.stop_at_null    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VALIDATE:  cfg_q.validate_enable <= cfg_data;
				CFG_STOP_NULL: cfg_q.stop_at_null    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign ready_s2  = !valid_s2 || !out_stall;
	assign load_s2   = valid_s1 && ready_s2;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign accept_in = in_valid && ready_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Saturate the word count
	assign n_lanes = (lanes_valid > ACTIVE_LANES_W) ? ACTIVE_LANES_W : lanes_valid;

	assign cp_in[0] = code_point_0;
	assign cp_in[1] = code_point_1;
	assign cp_in[2] = code_point_2;
	assign cp_in[3] = code_point_3;

	// One encoder per lane
	for (genvar k = 0; k < ACTIVE_LANES; k++) begin : g_lane
		u32u8enc_lane u_lane (
			.clk     (clk),
			.load    (accept_in),
			.act     (3'(k) < n_lanes),
			.cp      (cp_in[k]),
			.cfg     (cfg_q),
			.lane_s1 (lanes_s1[k])
		);
	end

	// Merge and output register
	u32u8enc_merge u_merge (
		.clk        (clk),
		.load       (load_s2),
		.lanes_s1   (lanes_s1),
		.bytes_low  (bytes_low),
		.bytes_high (bytes_high),
		.byte_count (byte_count),
		.lanes_done (lanes_done),
		.status     (status)
	);

	assign done_ext = {2'b00, lanes_done};
	assign done_x4  = {lanes_done, 2'b00};

	// Checks
	`U8E_ASSERT_NOW(a_done_range, out_valid, lanes_done <= ACTIVE_LANES_W)
	`U8E_ASSERT_NOW(a_count_fits, out_valid, byte_count >= done_ext && byte_count <= done_x4)
	`U8E_ASSERT_NOW(a_high_zero, out_valid && byte_count <= 5'd8, bytes_high == 64'h0)
	`U8E_ASSERT_NOW(a_room_taken, !valid_s1, !in_stall)
	`U8E_ASSERT_NEXT(a_s2_filled, load_s2, out_valid)

endmodule

// File: verif/tb_utf32_to_utf8_four_lane_encoder.sv
module tb_utf32_to_utf8_four_lane_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import u32u8enc_pkg::*;

	// cycles without any accepted request or result before the run is abandoned
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 100;
	localparam int RANDOM_PHASES = 7;
	localparam int MAX_PRINTED = 25;

	// one result as seen on the output port
	typedef struct packed {
		logic [63:0] bytes_low;
		logic [63:0] bytes_high;
		logic [4:0]  byte_count;
		logic [2:0]  lanes_done;
		status_t     status;
	} enc_result_t;

	// one request: four words and the count of leading words present
	typedef struct packed {
		logic [31:0] cp0;
		logic [31:0] cp1;
		logic [31:0] cp2;
		logic [31:0] cp3;
		logic [2:0]  lanes;
	} group_t;

	// directed row: settings, request, and a hand-written result where it is obvious
	typedef struct packed {
		cfg_t        cfg;
		group_t      grp;
		logic        typed;
		enc_result_t want;
	} row_t;

	localparam cfg_t CFG_STRICT      = '{validate_enable: 1'b1, stop_at_null: 1'b0};
	localparam cfg_t CFG_STRICT_NULL = '{validate_enable: 1'b1, stop_at_null: 1'b1};
	localparam cfg_t CFG_RAW         = '{validate_enable: 1'b0, stop_at_null: 1'b0};
	localparam cfg_t CFG_RAW_NULL    = '{validate_enable: 1'b0, stop_at_null: 1'b1};

	localparam enc_result_t NO_WANT   = '{64'h0, 64'h0, 5'd0, 3'd0, ST_OK};
	localparam enc_result_t EMPTY_BAD = '{64'h0, 64'h0, 5'd0, 3'd0, ST_INVALID};
	localparam enc_result_t EMPTY_END = '{64'h0, 64'h0, 5'd0, 3'd0, ST_TERM};

	localparam row_t DIRECTED [25] = '{
		// lane count zero encodes nothing
		'{CFG_STRICT, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0},
			1'b1, NO_WANT},
		// ASCII extremes, zero is plain data while null mode is off
		'{CFG_STRICT, '{32'h00, 32'h7F, 32'h41, 32'h20, 3'd4},
			1'b1, '{64'h2041_7F00, 64'h0, 5'd4, 3'd4, ST_OK}},
		// two- and three-byte boundaries
		'{CFG_STRICT, '{32'h80, 32'h7FF, 32'h800, 32'hFFFD, 3'd4}, 1'b0, NO_WANT},
		// four four-byte forms fill all sixteen bytes
		'{CFG_STRICT, '{32'h1_0000, 32'h10_FFFD, 32'h1_F600, 32'h2_0000, 3'd4},
			1'b0, NO_WANT},
		// surrogate in lane 0
		'{CFG_STRICT, '{32'hD800, 32'h41, 32'h41, 32'h41, 3'd4}, 1'b1, EMPTY_BAD},
		// surrogate in lane 1
		'{CFG_STRICT, '{32'h41, 32'hDFFF, 32'h41, 32'h41, 3'd4}, 1'b0, NO_WANT},
		// largest word
		'{CFG_STRICT, '{32'hFFFF_FFFF, 32'h41, 32'h41, 32'h41, 3'd4}, 1'b1, EMPTY_BAD},
		// just past the last code point
		'{CFG_STRICT, '{32'h41, 32'h10_FFFD, 32'h11_0000, 32'h41, 3'd4}, 1'b0, NO_WANT},
		// edges of the noncharacter block
		'{CFG_STRICT, '{32'hFDCF, 32'hFDF0, 32'hE9, 32'hFDD0, 3'd4}, 1'b0, NO_WANT},
		'{CFG_STRICT, '{32'h41, 32'hFDEF, 32'h0, 32'h0, 3'd4}, 1'b0, NO_WANT},
		// FFFE/FFFF in the BMP and in a supplementary plane
		'{CFG_STRICT, '{32'hFFFE, 32'h0, 32'h0, 32'h0, 3'd4}, 1'b1, EMPTY_BAD},
		'{CFG_STRICT, '{32'h41, 32'h42, 32'h1_FFFF, 32'h43, 3'd4}, 1'b0, NO_WANT},
		// lane count above four saturates
		'{CFG_STRICT, '{32'h41, 32'h42, 32'h43, 32'h44, 3'd7}, 1'b0, NO_WANT},
		// partial tails
		'{CFG_STRICT, '{32'h3A9, 32'h20AC, 32'h1_F600, 32'h7A, 3'd3}, 1'b0, NO_WANT},
		'{CFG_STRICT, '{32'h41, 32'hDBFF, 32'h0, 32'h0, 3'd1}, 1'b0, NO_WANT},
		// terminator handling
		'{CFG_STRICT_NULL, '{32'h0, 32'h41, 32'h41, 32'h41, 3'd4}, 1'b1, EMPTY_END},
		'{CFG_STRICT_NULL, '{32'h41, 32'h0, 32'hD800, 32'h41, 3'd4}, 1'b0, NO_WANT},
		'{CFG_STRICT_NULL, '{32'hD800, 32'h0, 32'h41, 32'h41, 3'd4}, 1'b1, EMPTY_BAD},
		'{CFG_STRICT_NULL, '{32'h41, 32'h42, 32'h0, 32'h43, 3'd2}, 1'b0, NO_WANT},
		// validation off: rejected values pass through
		'{CFG_RAW, '{32'hD800, 32'hFFFF, 32'hFDD0, 32'h11_0000, 3'd4}, 1'b0, NO_WANT},
		'{CFG_RAW, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4},
			1'b0, NO_WANT},
		'{CFG_RAW, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h10_FFFF, 3'd4}, 1'b0, NO_WANT},
		'{CFG_RAW_NULL, '{32'h0, 32'h41, 32'h0, 32'h0, 3'd4}, 1'b1, EMPTY_END},
		'{CFG_RAW_NULL, '{32'hFFFF_FFFF, 32'hDFFF, 32'h0, 32'h41, 3'd4}, 1'b0, NO_WANT},
		'{CFG_RAW_NULL, '{32'h41, 32'h42, 32'h43, 32'h44, 3'd4}, 1'b0, NO_WANT}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] code_point_0;
	logic [31:0] code_point_1;
	logic [31:0] code_point_2;
	logic [31:0] code_point_3;
	logic [2:0]  lanes_valid;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] bytes_low;
	logic [63:0] bytes_high;
	logic [4:0]  byte_count;
	logic [2:0]  lanes_done;
	logic [1:0]  status;

	enc_result_t expected_utf8 [$];
	cfg_t        cfg_model;
	bit          calm;
	int          errors;
	int          requests_sent;
	int          results_seen;
	int          seen_ok;
	int          seen_invalid;
	int          seen_term;
	int          bytes_seen;
	int          stall_left;
	int          idle_cycles;

	utf32_to_utf8_four_lane_encoder DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(string msg);
		if (errors < MAX_PRINTED)
			$display("[%0t] ERROR: %s", $realtime, msg);
		errors++;
	endtask

	function automatic bit code_point_rejected(logic [31:0] cp);
		return (cp >= CP_MAX_PLUS1) || ((cp & SURR_MASK) == SURR_BASE) ||
			(cp >= NONCHAR_LO && cp <= NONCHAR_HI) ||
			((cp & NONCHAR_LOW16) == NONCHAR_LOW16);
	endfunction

	function automatic void put_utf8_byte(inout logic [127:0] packed_out, inout int pos,
			input logic [7:0] b);
		packed_out[pos*8 +: 8] = b;
		pos++;
	endfunction

	// expected result of one request under the given settings
	function automatic enc_result_t encode_group(group_t g, cfg_t c);
		logic [31:0]  lane_cp [4];
		logic [127:0] packed_out;
		logic [31:0]  cp;
		logic [20:0]  c21;
		int           n;
		int           pos;
		int           done;
		bit           halted;
		enc_result_t  r;
		lane_cp = '{g.cp0, g.cp1, g.cp2, g.cp3};
		n = (g.lanes > ACTIVE_LANES_W) ? ACTIVE_LANES : int'(g.lanes);
		packed_out = '0;
		pos = 0;
		done = 0;
		halted = 1'b0;
		r.status = ST_OK;
		for (int k = 0; k < n && !halted; k++) begin
			cp = lane_cp[k];
			if (c.stop_at_null && cp == 32'h0) begin
				r.status = ST_TERM;
				halted = 1'b1;
			end else if (c.validate_enable && code_point_rejected(cp)) begin
				r.status = ST_INVALID;
				halted = 1'b1;
			end else begin
				if (cp < CP_1B_LIMIT) begin
					put_utf8_byte(packed_out, pos, cp[7:0]);
				end else if (cp < CP_2B_LIMIT) begin
					put_utf8_byte(packed_out, pos, LEAD_2B | {3'b0, cp[10:6]});
					put_utf8_byte(packed_out, pos, CONT_B | {2'b0, cp[5:0]});
				end else if (cp < CP_3B_LIMIT) begin
					put_utf8_byte(packed_out, pos, LEAD_3B | {4'b0, cp[15:12]});
					put_utf8_byte(packed_out, pos, CONT_B | {2'b0, cp[11:6]});
					put_utf8_byte(packed_out, pos, CONT_B | {2'b0, cp[5:0]});
				end else begin
					// anything wider keeps only its low 21 bits
					c21 = cp[20:0];
					put_utf8_byte(packed_out, pos, LEAD_4B | {5'b0, c21[20:18]});
					put_utf8_byte(packed_out, pos, CONT_B | {2'b0, c21[17:12]});
					put_utf8_byte(packed_out, pos, CONT_B | {2'b0, c21[11:6]});
					put_utf8_byte(packed_out, pos, CONT_B | {2'b0, c21[5:0]});
				end
				done++;
			end
		end
		r.bytes_low = packed_out[63:0];
		r.bytes_high = packed_out[127:64];
		r.byte_count = 5'(pos);
		r.lanes_done = 3'(done);
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// well-formed word, or one of the kinds that validation or null mode stops on
	function automatic logic [31:0] pick_code_point(bit well_formed);
		logic [31:0] cp;
		int          r;
		r = well_formed ? $urandom_range(0, 89) : $urandom_range(90, 99);
		if (r < 30) begin
			cp = $urandom_range(1, 127);
		end else if (r < 48) begin
			cp = $urandom_range(32'h80, 32'h7FF);
		end else if (r < 68) begin
			do cp = $urandom_range(32'h800, 32'hFFFF); while (code_point_rejected(cp));
		end else if (r < 90) begin
			do cp = $urandom_range(32'h1_0000, 32'h10_FFFF); while (code_point_rejected(cp));
		end else begin
			case ($urandom_range(0, 5))
				0: cp = $urandom_range(32'hD800, 32'hDFFF);
				1: cp = $urandom_range(32'hFDD0, 32'hFDEF);
				2: cp = {11'h0, 5'($urandom_range(0, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
				3: cp = $urandom_range(32'h11_0000, 32'h1F_FFFF);
				4: cp = 32'h0;
				default: cp = $urandom;
			endcase
		end
		return cp;
	endfunction

	function automatic group_t pick_group();
		group_t g;
		int     bad_lane;
		g.cp0 = pick_code_point(1'b1);
		g.cp1 = pick_code_point(1'b1);
		g.cp2 = pick_code_point(1'b1);
		g.cp3 = pick_code_point(1'b1);
		g.lanes = ($urandom_range(0, 99) < 75) ? 3'd4 : 3'($urandom_range(0, 7));
		// a share of broken groups: one lane replaced by noise
		if ($urandom_range(0, 99) < 20) begin
			bad_lane = $urandom_range(0, 3);
			case (bad_lane)
				0: g.cp0 = pick_code_point(1'b0);
				1: g.cp1 = pick_code_point(1'b0);
				2: g.cp2 = pick_code_point(1'b0);
				default: g.cp3 = pick_code_point(1'b0);
			endcase
		end
		return g;
	endfunction

	// present one request and hold it until accepted; called at a rising edge
	task automatic push_group(group_t g, enc_result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_point_0 <= g.cp0;
		code_point_1 <= g.cp1;
		code_point_2 <= g.cp2;
		code_point_3 <= g.cp3;
		lanes_valid <= g.lanes;
		do @(posedge clk); while (in_stall);
		expected_utf8.push_back(want);
		requests_sent++;
	endtask

	// stop sending and let the pipeline empty before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_utf8.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VALIDATE;
		cfg_data <= c.validate_enable;
		@(posedge clk);
		cfg_index <= CFG_STOP_NULL;
		cfg_data <= c.stop_at_null;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_model = c;
	endtask

	// stimulus
	initial begin
		group_t      g;
		enc_result_t want;
		cfg_t        phase_cfg;
		cfg_we <= 1'b0;
		cfg_index <= CFG_VALIDATE;
		cfg_data <= 1'b0;
		in_valid <= 1'b0;
		code_point_0 <= '0;
		code_point_1 <= '0;
		code_point_2 <= '0;
		code_point_3 <= '0;
		lanes_valid <= '0;
		arst_n = 1'b0;
		calm = 1'b0;
		cfg_model = CFG_STRICT;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed table, starting from the reset settings
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].cfg != cfg_model) begin
				drain();
				apply_config(DIRECTED[i].cfg);
			end
			g = DIRECTED[i].grp;
			want = DIRECTED[i].typed ? DIRECTED[i].want : encode_group(g, cfg_model);
			push_group(g, want);
		end

		// random phases: every setting first, then random ones
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: phase_cfg = CFG_RAW;
				1: phase_cfg = CFG_STRICT_NULL;
				2: phase_cfg = CFG_RAW_NULL;
				3: phase_cfg = CFG_STRICT;
				default: phase_cfg = cfg_t'(2'($urandom_range(0, 3)));
			endcase
			drain();
			apply_config(phase_cfg);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				g = pick_group();
				push_group(g, encode_group(g, cfg_model));
			end
		end

		// wait for the tail, then a few quiet cycles to catch strays
		calm = 1'b0;
		in_valid <= 1'b0;
		while (expected_utf8.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_utf8.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_utf8.size()));
		$display("Summary: %0d requests sent, %0d results checked, %0d bytes encoded",
			requests_sent, results_seen, bytes_seen);
		$display("Summary: status ok %0d, invalid %0d, terminator %0d, errors %0d",
			seen_ok, seen_invalid, seen_term, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	task automatic check_result(enc_result_t got, enc_result_t want);
		if (got.bytes_low !== want.bytes_low)
			report_error($sformatf("bytes_low got %h want %h", got.bytes_low, want.bytes_low));
		if (got.bytes_high !== want.bytes_high)
			report_error($sformatf("bytes_high got %h want %h", got.bytes_high,
				want.bytes_high));
		if (got.byte_count !== want.byte_count)
			report_error($sformatf("byte_count got %0d want %0d", got.byte_count,
				want.byte_count));
		if (got.lanes_done !== want.lanes_done)
			report_error($sformatf("lanes_done got %0d want %0d", got.lanes_done,
				want.lanes_done));
		if (got.status !== want.status)
			report_error($sformatf("status got %0d want %0d", got.status, want.status));
	endtask

	// result checking, output stall and watchdog
	always @(posedge clk) begin
		enc_result_t got;
		int          r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{bytes_low, bytes_high, byte_count, lanes_done, status_t'(status)};
				results_seen++;
				bytes_seen += int'(byte_count);
				case (got.status)
					ST_OK:      seen_ok++;
					ST_INVALID: seen_invalid++;
					ST_TERM:    seen_term++;
					default:    ;
				endcase
				if (expected_utf8.size() == 0)
					report_error("result with no request outstanding");
				else
					check_result(got, expected_utf8.pop_front());
			end

			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				report_error($sformatf("no progress for %0d cycles", IDLE_LIMIT));
				$display("Test completed with failures");
				$finish;
			end

			if (stall_left == 0 && !calm) begin
				r = $urandom_range(0, 99);
				if (r < 18)
					stall_left = $urandom_range(1, 3);
				else if (r < 21)
					stall_left = $urandom_range(10, 30);
			end
			if (calm)
				stall_left = 0;
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		out_stall <= 1'b0;
		errors = 0;
		requests_sent = 0;
		results_seen = 0;
		seen_ok = 0;
		seen_invalid = 0;
		seen_term = 0;
		bytes_seen = 0;
		stall_left = 0;
		idle_cycles = 0;
	end

endmodule

// File: files.f
+incdir+sv
sv/u32u8enc_pkg.sv
sv/u32u8enc_lane.sv
sv/u32u8enc_merge.sv
sv/utf32_to_utf8_four_lane_encoder.sv
verif/tb_utf32_to_utf8_four_lane_encoder.sv
